// ----- hdl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg: shared types for the tick priority scheduler
// Command and result transfer structs, cell control group, fixed field widths.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned SLEEP_W = 16;
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned INDEX_W = 3;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  operation;
    logic [INDEX_W-1:0]   entry_index;
    logic [FIELD_W-1:0]   entry_priority;
    logic [FIELD_W-1:0]   entry_ticks;
    logic [SLEEP_W-1:0]   entry_sleep;
    logic                 entry_waiting;
  } cmd_t;

  typedef struct packed {
    logic [INDEX_W-1:0] selected_entry;
    logic               none_ready;
  } result_t;

  typedef struct packed {
    logic wr;
    logic dec;
    logic refill;
  } cell_ctrl_t;

endpackage

// ----- hdl/tps_cell.sv -----
// ----------------------------------------------------------------------------
// tps_cell: one process entry of the scheduler chain
// Holds priority, ticks, sleep and waiting of one entry and passes the best
// candidate so far on to its right-hand neighbour each cycle.
// ----------------------------------------------------------------------------
module tps_cell #(
  parameter int unsigned TICK_WIDTH = 8,
  parameter int unsigned IDX_W      = 3,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tps_pkg::cell_ctrl_t          ctrl_i,
  input  logic [TICK_WIDTH-1:0]        wr_prio_i,
  input  logic [TICK_WIDTH-1:0]        wr_ticks_i,
  input  logic [tps_pkg::SLEEP_W-1:0]  wr_sleep_i,
  input  logic                         wr_waiting_i,
  input  logic [TICK_WIDTH-1:0]        cand_ticks_i,
  input  logic [IDX_W-1:0]             cand_idx_i,
  input  logic                         cand_found_i,
  output logic [TICK_WIDTH-1:0]        cand_ticks_o,
  output logic [IDX_W-1:0]             cand_idx_o,
  output logic                         cand_found_o
);

  logic [TICK_WIDTH-1:0]       prio_q, prio_d;
  logic [TICK_WIDTH-1:0]       ticks_q, ticks_d;
  logic [tps_pkg::SLEEP_W-1:0] sleep_q, sleep_d;
  logic                        waiting_q, waiting_d;
  logic [TICK_WIDTH-1:0]       cticks_q, cticks_d;
  logic [IDX_W-1:0]            cidx_q, cidx_d;
  logic                        cfound_q, cfound_d;
  logic                        ready;
  logic                        take;

  assign ready = !waiting_q && (sleep_q == '0);
  assign take  = ready && (ticks_q > cand_ticks_i);

  always_comb begin
    prio_d    = prio_q;
    ticks_d   = ticks_q;
    sleep_d   = sleep_q;
    waiting_d = waiting_q;
    if (ctrl_i.wr) begin
      prio_d    = wr_prio_i;
      ticks_d   = wr_ticks_i;
      sleep_d   = wr_sleep_i;
      waiting_d = wr_waiting_i;
    end else begin
      if (ctrl_i.dec && (sleep_q != '0)) begin
        sleep_d = sleep_q - tps_pkg::SLEEP_W'(1);
      end
      if (ctrl_i.refill && ready) begin
        ticks_d = prio_q;
      end
    end
  end

  always_comb begin
    cticks_d = take ? ticks_q : cand_ticks_i;
    cidx_d   = take ? IDX_W'(CELL_IDX) : cand_idx_i;
    cfound_d = cand_found_i || take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q    <= '0;
      ticks_q   <= '0;
      sleep_q   <= '0;
      waiting_q <= 1'b0;
      cticks_q  <= '0;
      cidx_q    <= '0;
      cfound_q  <= 1'b0;
    end else begin
      prio_q    <= prio_d;
      ticks_q   <= ticks_d;
      sleep_q   <= sleep_d;
      waiting_q <= waiting_d;
      cticks_q  <= cticks_d;
      cidx_q    <= cidx_d;
      cfound_q  <= cfound_d;
    end
  end

  assign cand_ticks_o = cticks_q;
  assign cand_idx_o   = cidx_q;
  assign cand_found_o = cfound_q;

endmodule

// ----- hdl/tick_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// tick_priority_scheduler: remaining-ticks priority scheduler
// A write loads one table entry; a schedule picks the ready entry with the
// most ticks left, refilling ticks from priority once if none has any.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A write does not
// raise busy and its result strobe follows in the next cycle. A schedule
// holds busy through a first scan of the chain and its evaluation, and,
// when the first pass finds no entry, through a refill, a second scan and
// its evaluation; the result strobe appears in the first cycle after busy
// falls. The length of a schedule is set by the candidate moving one cell
// per cycle along the chain of entry cells. Results are presented for one
// cycle only and cannot be held off.
module tick_priority_scheduler #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned TICK_WIDTH    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tps_pkg::cmd_t    cmd_i,
  output logic             result_valid_o,
  output tps_pkg::result_t result_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN1 = 5'b00010,
    ST_EVAL1 = 5'b00100,
    ST_SCAN2 = 5'b01000,
    ST_EVAL2 = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   choice_q, choice_d;
  logic               res_valid_q, res_valid_d;
  logic               res_none_q, res_none_d;
  logic               accept;
  logic               wr_acc;
  logic               sched_acc;
  logic               refill;
  logic               cnt_last;
  logic               best_found;
  logic [IDX_W-1:0]   best_idx;

  logic [TICK_WIDTH-1:0] ch_ticks [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]      ch_idx   [0:TABLE_ENTRIES];
  logic                  ch_found [0:TABLE_ENTRIES];

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign wr_acc    = accept && (cmd_i.operation == tps_pkg::OP_WRITE);
  assign sched_acc = accept && (cmd_i.operation == tps_pkg::OP_SCHEDULE);
  assign cnt_last  = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));

  // chain seed
  assign ch_ticks[0] = '0;
  assign ch_idx[0]   = '0;
  assign ch_found[0] = 1'b0;

  assign best_found = ch_found[TABLE_ENTRIES];
  assign best_idx   = ch_idx[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tps_pkg::cell_ctrl_t ctrl;

    assign ctrl.wr     = wr_acc && (32'(cmd_i.entry_index) == g);
    assign ctrl.dec    = sched_acc;
    assign ctrl.refill = refill;

    tps_cell #(
      .TICK_WIDTH (TICK_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .wr_prio_i    (TICK_WIDTH'(cmd_i.entry_priority)),
      .wr_ticks_i   (TICK_WIDTH'(cmd_i.entry_ticks)),
      .wr_sleep_i   (cmd_i.entry_sleep),
      .wr_waiting_i (cmd_i.entry_waiting),
      .cand_ticks_i (ch_ticks[g]),
      .cand_idx_i   (ch_idx[g]),
      .cand_found_i (ch_found[g]),
      .cand_ticks_o (ch_ticks[g+1]),
      .cand_idx_o   (ch_idx[g+1]),
      .cand_found_o (ch_found[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    choice_d    = choice_q;
    res_valid_d = 1'b0;
    res_none_d  = res_none_q;
    refill      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (wr_acc) begin
          res_valid_d = 1'b1;
          res_none_d  = 1'b0;
        end else if (sched_acc) begin
          state_d = ST_SCAN1;
          cnt_d   = '0;
        end
      end
      ST_SCAN1: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_last) begin
          state_d = ST_EVAL1;
        end
      end
      ST_EVAL1: begin
        if (best_found) begin
          choice_d    = best_idx;
          res_valid_d = 1'b1;
          res_none_d  = 1'b0;
          state_d     = ST_IDLE;
        end else begin
          refill  = 1'b1;
          cnt_d   = '0;
          state_d = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_last) begin
          state_d = ST_EVAL2;
        end
      end
      ST_EVAL2: begin
        if (best_found) begin
          choice_d = best_idx;
        end
        res_valid_d = 1'b1;
        res_none_d  = !best_found;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      choice_q    <= '0;
      res_valid_q <= 1'b0;
      res_none_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      choice_q    <= choice_d;
      res_valid_q <= res_valid_d;
      res_none_q  <= res_none_d;
    end
  end

  assign result_valid_o          = res_valid_q;
  assign result_o.selected_entry = tps_pkg::INDEX_W'(choice_q);
  assign result_o.none_ready     = res_none_q;

  // assertions
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("scheduler state not one-hot");

  a_result_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while a schedule is in progress");

  a_write_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |=> result_valid_o && !result_o.none_ready)
    else $error("write transfer not followed by its result");

  a_none_keeps_choice : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.none_ready) |-> (choice_q == $past(choice_q)))
    else $error("selection changed on a none-ready result");

  a_refill_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    refill |-> (state_q == ST_EVAL1))
    else $error("refill outside the first evaluation");

endmodule

// ----- sim/tps_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tps_checker: selection predictor and result checker
// Tracks its own copy of the process table, works out the selection for
// every accepted command and compares each result strobe against the oldest
// outstanding selection.
// ----------------------------------------------------------------------------
module tps_checker
  import tps_pkg::*;
#(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned TICK_W  = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  cmd_t    cmd_i,
  input  logic    result_valid_i,
  input  result_t result_i,
  output int      fail_count_o,
  output int      outstanding_o
);

  logic [TICK_W-1:0]  prio_tbl  [ENTRIES];
  logic [TICK_W-1:0]  ticks_tbl [ENTRIES];
  logic [SLEEP_W-1:0] sleep_tbl [ENTRIES];
  logic               wait_tbl  [ENTRIES];
  logic [INDEX_W-1:0] last_choice;

  result_t selection_queue[$];
  result_t want;
  int      mismatches;

  assign fail_count_o  = mismatches;
  assign outstanding_o = selection_queue.size();

  function automatic logic entry_ready(int i);
    return !wait_tbl[i] && (sleep_tbl[i] == '0);
  endfunction

  // largest nonzero ticks among ready entries, lowest index on a tie
  function automatic logic best_ready(output logic [INDEX_W-1:0] pick);
    logic [TICK_W-1:0] best;
    logic              found;
    best  = '0;
    found = 1'b0;
    pick  = last_choice;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_ready(i) && ticks_tbl[i] > best) begin
        best  = ticks_tbl[i];
        pick  = INDEX_W'(i);
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic result_t predict_selection(cmd_t c);
    result_t            r;
    logic [INDEX_W-1:0] pick;
    logic               none;
    none = 1'b0;
    if (c.operation == OP_WRITE) begin
      if (int'(c.entry_index) < ENTRIES) begin
        prio_tbl[c.entry_index]  = c.entry_priority[TICK_W-1:0];
        ticks_tbl[c.entry_index] = c.entry_ticks[TICK_W-1:0];
        sleep_tbl[c.entry_index] = c.entry_sleep;
        wait_tbl[c.entry_index]  = c.entry_waiting;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sleep_tbl[i] != '0) sleep_tbl[i] = sleep_tbl[i] - 1'b1;
      end
      if (!best_ready(pick)) begin
        // refill from priority, then one more pass
        for (int i = 0; i < ENTRIES; i++) begin
          if (entry_ready(i)) ticks_tbl[i] = prio_tbl[i];
        end
        if (!best_ready(pick)) none = 1'b1;
      end
      if (!none) last_choice = pick;
    end
    r.selected_entry = last_choice;
    r.none_ready     = none;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        prio_tbl[i]  = '0;
        ticks_tbl[i] = '0;
        sleep_tbl[i] = '0;
        wait_tbl[i]  = 1'b0;
      end
      last_choice = '0;
      mismatches  = 0;
      selection_queue.delete();
    end else begin
      // result of the previous command first, it may share an edge with a new transfer
      if (result_valid_i) begin
        if (selection_queue.size() == 0) begin
          $error("result strobe with no command outstanding");
          mismatches++;
        end else begin
          want = selection_queue.pop_front();
          if (result_i.selected_entry !== want.selected_entry) begin
            $error("selected_entry: expected %0d, actual %0d",
                   want.selected_entry, result_i.selected_entry);
            mismatches++;
          end
          if (result_i.none_ready !== want.none_ready) begin
            $error("none_ready: expected %0d, actual %0d",
                   want.none_ready, result_i.none_ready);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) selection_queue.push_back(predict_selection(cmd_i));
    end
  end

endmodule

// ----- sim/tb_tick_priority_scheduler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tick_priority_scheduler: testbench top for the tick priority scheduler
// Drives a directed set of writes and schedules, then random command
// traffic with random gaps and idle-free bursts; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tick_priority_scheduler;
  import tps_pkg::*;

  localparam int unsigned ENTRIES     = 8;
  localparam int unsigned TICK_W      = 8;
  localparam int          RAND_ITEMS  = 500;
  localparam int          CYCLE_LIMIT = 200000;

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  cmd_t    cmd    = '0;
  logic    result_valid;
  result_t result;
  int      fail_count;
  int      outstanding;
  int      cycle_count = 0;
  logic    steady = 1'b0;

  tick_priority_scheduler #(
    .TABLE_ENTRIES (ENTRIES),
    .TICK_WIDTH    (TICK_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  tps_checker #(
    .ENTRIES (ENTRIES),
    .TICK_W  (TICK_W)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .result_valid_i (result_valid),
    .result_i       (result),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic cmd_t entry_cmd(op_e op, int idx, int prio, int ticks, int sleep,
                                     logic waiting);
    cmd_t c;
    c.operation      = op;
    c.entry_index    = INDEX_W'(idx);
    c.entry_priority = FIELD_W'(prio);
    c.entry_ticks    = FIELD_W'(ticks);
    c.entry_sleep    = SLEEP_W'(sleep);
    c.entry_waiting  = waiting;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.operation      = ($urandom_range(0, 1) == 1) ? OP_SCHEDULE : OP_WRITE;
    c.entry_index    = INDEX_W'($urandom_range(0, ENTRIES - 1));
    c.entry_priority = ($urandom_range(0, 4) == 0) ? '0 : FIELD_W'($urandom_range(0, 255));
    c.entry_ticks    = ($urandom_range(0, 4) < 2) ? '0 : FIELD_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: c.entry_sleep = SLEEP_W'($urandom_range(0, 65535));
      1, 2, 3: c.entry_sleep = SLEEP_W'($urandom_range(1, 4));
      default: c.entry_sleep = '0;
    endcase
    c.entry_waiting  = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  // start is left high after a transfer so back-to-back commands need one assignment
  task automatic issue(cmd_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
  endtask

  // one edge first so the checker has seen the last transfer
  task automatic drain();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, ties, refill, sleep wake-up
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 0, 255, 255, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 7, 0, 0, 65535, 1'b1));
    issue(entry_cmd(OP_SCHEDULE, 7, 255, 255, 65535, 1'b1));
    issue(entry_cmd(OP_WRITE, 1, 200, 255, 0, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 0, 255, 255, 0, 1'b1));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 2, 10, 0, 1, 1'b0));
    issue(entry_cmd(OP_WRITE, 1, 50, 0, 0, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 1, 0, 0, 0, 1'b1));
    issue(entry_cmd(OP_WRITE, 2, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 3, 'h5a, 'ha5, 2, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 4, 'ha5, 'h5a, 'haaaa, 1'b0));
    issue(entry_cmd(OP_WRITE, 5, 'h0f, 'hf0, 'h5555, 1'b0));
    issue(entry_cmd(OP_WRITE, 6, 1, 1, 0, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    issue(entry_cmd(OP_WRITE, 7, 255, 0, 0, 1'b0));
    issue(entry_cmd(OP_SCHEDULE, 0, 0, 0, 0, 1'b0));
    start <= 1'b0;
    drain();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RAND_ITEMS / 2) begin
        start <= 1'b0;
        drain();
      end
      issue(random_cmd());
    end
    start <= 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
